// File: hw/rtl/cvfp_pkg.sv
// Shared types, constants and helper functions of the change-of-value frame publisher.
// No dependencies; the queue, controller, datapath, top level and testbench import this package.
package cvfp_pkg;

  // request type codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TX     = 1'b1;

  // value type codes of a sample request
  typedef enum logic [3:0] {
    TC_U8, TC_U16, TC_U32, TC_I8, TC_I16, TC_I32, TC_FLOAT,
    TC_ARR3, TC_ARR5, TC_ARR6, TC_ARR7, TC_DOUBLE
  } type_code_e;

  // number of defined type codes
  localparam logic [3:0] NUM_TYPES = 4'd12;

  // queue entry layout: tag {type, slot, segment} over value
  localparam int unsigned TAG_W   = 18;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned QENT_W  = TAG_W + VALUE_W;

  typedef logic [QENT_W-1:0] qent_t;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_en;   // sweep one last-value entry to zero
    logic capture;  // take the request and read the stores
    logic exec;     // compare, update stores, load the result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done; // sweep is at the last entry
  } dp_status_t;

  // frame length in bytes per type code
  function automatic logic [3:0] frame_len(input logic [3:0] code);
    logic [3:0] len;
    unique case (code)
      TC_U8, TC_I8:              len = 4'd2;
      TC_U16, TC_I16:            len = 4'd3;
      TC_U32, TC_I32, TC_FLOAT:  len = 4'd5;
      TC_ARR3:                   len = 4'd4;
      TC_ARR5:                   len = 4'd6;
      TC_ARR6:                   len = 4'd7;
      TC_ARR7, TC_DOUBLE:        len = 4'd8;
      default:                   len = 4'd1;
    endcase
    return len;
  endfunction

  // compared value width in bytes per type code
  function automatic logic [3:0] value_bytes(input logic [3:0] code);
    logic [3:0] nb;
    unique case (code)
      TC_U8, TC_I8:              nb = 4'd1;
      TC_U16, TC_I16:            nb = 4'd2;
      TC_U32, TC_I32, TC_FLOAT:  nb = 4'd4;
      TC_ARR3:                   nb = 4'd3;
      TC_ARR5:                   nb = 4'd5;
      TC_ARR6:                   nb = 4'd6;
      TC_ARR7:                   nb = 4'd7;
      TC_DOUBLE:                 nb = 4'd8;
      default:                   nb = 4'd0;
    endcase
    return nb;
  endfunction

  // mask covering the low nbytes bytes of a 64-bit word
  function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < nbytes) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/cvfp_queue.sv
// One frame FIFO: entry memory with registered head read, and wrap-phase pointers.
// Depends on cvfp_pkg.
module cvfp_queue import cvfp_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  input  logic  pop_i,
  output qent_t head_data_o,
  output logic  empty_o,
  output logic  full_o
);

  localparam int unsigned QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [QW-1:0] LAST_IDX = QW'(DEPTH - 1);

  qent_t         mem [DEPTH];
  qent_t         head_data_q;
  logic [QW-1:0] head_idx_q, tail_idx_q;
  logic          head_ph_q, tail_ph_q;

  // equal index: same phase means empty, opposite phase means full
  assign empty_o     = (head_idx_q == tail_idx_q) && (head_ph_q == tail_ph_q);
  assign full_o      = (head_idx_q == tail_idx_q) && (head_ph_q != tail_ph_q);
  assign head_data_o = head_data_q;

  // entry storage and registered head read
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_idx_q] <= push_data_i;
    end
    head_data_q <= mem[head_idx_q];
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx_q <= '0;
      head_ph_q  <= 1'b0;
      tail_idx_q <= '0;
      tail_ph_q  <= 1'b0;
    end else begin
      if (push_i) begin
        if (tail_idx_q == LAST_IDX) begin
          tail_idx_q <= '0;
          tail_ph_q  <= ~tail_ph_q;
        end else begin
          tail_idx_q <= tail_idx_q + 1'b1;
        end
      end
      if (pop_i) begin
        if (head_idx_q == LAST_IDX) begin
          head_idx_q <= '0;
          head_ph_q  <= ~head_ph_q;
        end else begin
          head_idx_q <= head_idx_q + 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/cvfp_ctrl.sv
// Controller state machine: clearing sweep, request accept, execute step.
// Depends on cvfp_pkg.
module cvfp_ctrl import cvfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  dp_status_t status_i,
  output logic       busy,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/cvfp_datapath.sv
// Datapath: request capture, last-value store, compare, two frame FIFOs, result registers.
// Depends on cvfp_pkg and cvfp_queue.
module cvfp_datapath import cvfp_pkg::*; #(
  parameter int unsigned DICT_ENTRIES = 256,
  parameter int unsigned QUEUE_DEPTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        req_type_i,
  input  logic [7:0]  entry_i,
  input  logic [5:0]  segment_i,
  input  logic [7:0]  slot_i,
  input  logic [3:0]  type_code_i,
  input  logic        hi_prio_i,
  input  logic [63:0] sample_value_i,
  output logic        done_o,
  output logic        changed_o,
  output logic        dropped_o,
  output logic        frame_valid_o,
  output logic [10:0] frame_id_o,
  output logic [3:0]  frame_bytes_o,
  output logic [63:0] frame_payload_o
);

  localparam int unsigned AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(DICT_ENTRIES - 1);

  // configuration
  logic [4:0] node_id_q;

  // captured request
  logic          req_q, hi_q, in_range_q;
  logic [AW-1:0] addr_q;
  logic [5:0]    seg_q;
  logic [7:0]    slot_q;
  logic [3:0]    type_q;
  logic [63:0]   sample_q;

  // last-value store
  logic [63:0]   lv_mem [DICT_ENTRIES];
  logic [63:0]   lv_rd_q;
  logic [AW-1:0] clr_idx_q;
  logic          lv_we;
  logic [AW-1:0] lv_waddr;
  logic [63:0]   lv_wdata;

  // queues
  logic  hi_push, lo_push, hi_pop, lo_pop;
  logic  hi_empty, hi_full, lo_empty, lo_full;
  qent_t hi_head, lo_head, push_ent;

  // execute-step signals
  logic        is_sample, chg, tgt_full;
  logic [63:0] vmask, newval;
  qent_t       pop_ent;
  logic [5:0]  pop_seg;
  logic [7:0]  pop_slot;
  logic [3:0]  pop_type, pop_len;
  logic [63:0] pay_mask;

  // result registers
  logic        done_q, changed_q, dropped_q, fvalid_q;
  logic [10:0] fid_q;
  logic [3:0]  fbytes_q;
  logic [63:0] fpay_q;

  // node id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0;
    end else if (cfg_we_i) begin
      node_id_q <= cfg_wdata_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q      <= req_type_i;
      hi_q       <= hi_prio_i;
      in_range_q <= (32'(entry_i) < 32'(DICT_ENTRIES));
      addr_q     <= AW'(entry_i);
      seg_q      <= segment_i;
      slot_q     <= slot_i;
      type_q     <= type_code_i;
      sample_q   <= sample_value_i;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr_en && (clr_idx_q != LAST_ENTRY)) begin
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end
  assign status_o.clr_done = (clr_idx_q == LAST_ENTRY);

  // compare against the stored value over the type width
  assign is_sample = (req_q == REQ_SAMPLE);
  assign vmask     = byte_mask(value_bytes(type_q));
  assign chg       = is_sample && (type_q < NUM_TYPES) && in_range_q &&
                     (|((lv_rd_q ^ sample_q) & vmask));
  assign newval    = (lv_rd_q & ~vmask) | (sample_q & vmask);
  assign tgt_full  = hi_q ? hi_full : lo_full;

  // last-value write port: sweep or update
  always_comb begin
    lv_we    = 1'b0;
    lv_waddr = addr_q;
    lv_wdata = newval;
    if (cmd_i.clr_en) begin
      lv_we    = 1'b1;
      lv_waddr = clr_idx_q;
      lv_wdata = '0;
    end else if (cmd_i.exec && chg) begin
      lv_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lv_we) begin
      lv_mem[lv_waddr] <= lv_wdata;
    end
    if (cmd_i.capture) begin
      lv_rd_q <= lv_mem[AW'(entry_i)];
    end
  end

  // queue push and pop, high queue first on transmit
  assign push_ent = {type_q, slot_q, seg_q, sample_q & vmask};
  assign hi_push  = cmd_i.exec && chg && hi_q && !hi_full;
  assign lo_push  = cmd_i.exec && chg && !hi_q && !lo_full;
  assign hi_pop   = cmd_i.exec && !is_sample && !hi_empty;
  assign lo_pop   = cmd_i.exec && !is_sample && hi_empty && !lo_empty;

  cvfp_queue #(.DEPTH(QUEUE_DEPTH)) u_hi_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (hi_push),
    .push_data_i (push_ent),
    .pop_i       (hi_pop),
    .head_data_o (hi_head),
    .empty_o     (hi_empty),
    .full_o      (hi_full)
  );

  cvfp_queue #(.DEPTH(QUEUE_DEPTH)) u_lo_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (lo_push),
    .push_data_i (push_ent),
    .pop_i       (lo_pop),
    .head_data_o (lo_head),
    .empty_o     (lo_empty),
    .full_o      (lo_full)
  );

  // frame build from the popped entry
  assign pop_ent  = hi_empty ? lo_head : hi_head;
  assign pop_seg  = pop_ent[VALUE_W +: 6];
  assign pop_slot = pop_ent[VALUE_W + 6 +: 8];
  assign pop_type = pop_ent[VALUE_W + 14 +: 4];
  assign pop_len  = frame_len(pop_type);
  assign pay_mask = byte_mask(pop_len - 4'd1);

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      changed_q <= chg;
      dropped_q <= chg && tgt_full;
      if (!is_sample && !(hi_empty && lo_empty)) begin
        fvalid_q <= 1'b1;
        fid_q    <= {node_id_q, pop_seg};
        fbytes_q <= pop_len;
        fpay_q   <= {pop_ent[55:0] & pay_mask[55:0], pop_slot};
      end else begin
        fvalid_q <= 1'b0;
        fid_q    <= '0;
        fbytes_q <= '0;
        fpay_q   <= '0;
      end
    end
  end

  assign done_o          = done_q;
  assign changed_o       = changed_q;
  assign dropped_o       = dropped_q;
  assign frame_valid_o   = fvalid_q;
  assign frame_id_o      = fid_q;
  assign frame_bytes_o   = fbytes_q;
  assign frame_payload_o = fpay_q;

endmodule

// File: hw/rtl/change_of_value_frame_publisher_core.sv
// Top level of the change-of-value frame publisher: controller plus datapath.
// Depends on cvfp_pkg, cvfp_ctrl and cvfp_datapath.
//
// A request is taken when start is high while busy is low. Sample requests
// compare the value with the entry's last value and queue a frame on change;
// transmit requests pop one frame, high queue first. The accept cycle reads
// the last-value store and both queue heads, and the next cycle compares
// and updates the stores. Exactly one result follows per request, with
// done_o high for one cycle, registered from the execute step; it cannot be
// held off, so it must be taken when shown. A new request may
// be accepted in the same cycle the previous result is shown. After reset
// the block sweeps the last-value store to zero, one entry per cycle, and
// stays busy until every entry is cleared. node_id may be written at any idle
// time through cfg_we_i and cfg_wdata_i.
module change_of_value_frame_publisher_core import cvfp_pkg::*; #(
  parameter int unsigned DICT_ENTRIES = 256,
  parameter int unsigned QUEUE_DEPTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        req_type_i,
  input  logic [7:0]  entry_i,
  input  logic [5:0]  segment_i,
  input  logic [7:0]  slot_i,
  input  logic [3:0]  type_code_i,
  input  logic        hi_prio_i,
  input  logic [63:0] sample_value_i,
  output logic        done_o,
  output logic        changed_o,
  output logic        dropped_o,
  output logic        frame_valid_o,
  output logic [10:0] frame_id_o,
  output logic [3:0]  frame_bytes_o,
  output logic [63:0] frame_payload_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cvfp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  cvfp_datapath #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .entry_i         (entry_i),
    .segment_i       (segment_i),
    .slot_i          (slot_i),
    .type_code_i     (type_code_i),
    .hi_prio_i       (hi_prio_i),
    .sample_value_i  (sample_value_i),
    .done_o          (done_o),
    .changed_o       (changed_o),
    .dropped_o       (dropped_o),
    .frame_valid_o   (frame_valid_o),
    .frame_id_o      (frame_id_o),
    .frame_bytes_o   (frame_bytes_o),
    .frame_payload_o (frame_payload_o)
  );

endmodule

// File: hw/rtl/cvfp_checker.sv
// Port-level checker for the change-of-value frame publisher, bound to the top level.
// Depends on change_of_value_frame_publisher_core.
module cvfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       changed_o,
  input logic       dropped_o,
  input logic       frame_valid_o,
  input logic [3:0] frame_bytes_o
);

  // an accepted request occupies the block on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting a request");

  // every accepted request yields its result, a done_o pulse
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("result missing two cycles after accept");

  // a result is either a sample outcome or a frame, never both
  a_sample_or_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(changed_o && frame_valid_o))
    else $error("result flags both a change and a frame");

  // a drop only happens on a changed sample
  a_drop_implies_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && dropped_o |-> changed_o)
    else $error("drop reported without a change");

  // no frame means zero length, a frame carries two to eight bytes
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (frame_valid_o ? (frame_bytes_o >= 4'd2 && frame_bytes_o <= 4'd8)
                              : (frame_bytes_o == 4'd0)))
    else $error("frame length inconsistent with frame valid");

endmodule

bind change_of_value_frame_publisher_core cvfp_checker u_cvfp_checker (.*);

// File: verif/change_of_value_frame_publisher_core_tb.sv
// Self-checking testbench for change_of_value_frame_publisher_core: random and directed
// sample/transmit requests, a behavioral predictor of the frame queues, result checking.
// Depends on cvfp_pkg and the RTL of the publisher core.
module change_of_value_frame_publisher_core_tb;
  import cvfp_pkg::*;

  localparam int unsigned DICT_SIZE   = 256;
  localparam int unsigned QUEUE_SLOTS = 16;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  entry;
    logic [5:0]  segment;
    logic [7:0]  slot;
    logic [3:0]  type_code;
    logic        hi_prio;
    logic [63:0] sample_value;
  } cov_request_t;

  typedef struct packed {
    logic        changed;
    logic        dropped;
    logic        frame_valid;
    logic [10:0] frame_id;
    logic [3:0]  frame_bytes;
    logic [63:0] frame_payload;
  } frame_result_t;

  typedef struct packed {
    logic [5:0]  segment;
    logic [7:0]  slot;
    logic [3:0]  type_code;
    logic [63:0] value;
  } queued_frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        req_type_i = 1'b0;
  logic [7:0]  entry_i = '0;
  logic [5:0]  segment_i = '0;
  logic [7:0]  slot_i = '0;
  logic [3:0]  type_code_i = '0;
  logic        hi_prio_i = 1'b0;
  logic [63:0] sample_value_i = '0;
  logic        done_o;
  logic        changed_o;
  logic        dropped_o;
  logic        frame_valid_o;
  logic [10:0] frame_id_o;
  logic [3:0]  frame_bytes_o;
  logic [63:0] frame_payload_o;

  // predictor state
  logic [63:0]   last_value [DICT_SIZE];
  queued_frame_t high_frames [$];
  queued_frame_t low_frames [$];
  logic [4:0]    node_id = '0;

  cov_request_t  pending_requests [$];
  frame_result_t expected_results [$];
  cov_request_t  request_on_port;
  logic          holding = 1'b0;
  int            gap_pct = 0;

  // generator history: last sample value sent per entry
  logic [63:0]   recent_value [DICT_SIZE];

  int mismatches = 0;
  int n_samples = 0, n_transmits = 0, n_queued = 0, n_dropped = 0;
  int n_sent = 0, n_empty_tx = 0;

  change_of_value_frame_publisher_core #(
    .DICT_ENTRIES(DICT_SIZE),
    .QUEUE_DEPTH (QUEUE_SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .entry_i        (entry_i),
    .segment_i      (segment_i),
    .slot_i         (slot_i),
    .type_code_i    (type_code_i),
    .hi_prio_i      (hi_prio_i),
    .sample_value_i (sample_value_i),
    .done_o         (done_o),
    .changed_o      (changed_o),
    .dropped_o      (dropped_o),
    .frame_valid_o  (frame_valid_o),
    .frame_id_o     (frame_id_o),
    .frame_bytes_o  (frame_bytes_o),
    .frame_payload_o(frame_payload_o)
  );

  always #5 clk_i = ~clk_i;

  // frame length on the bus per type code
  function automatic int wire_length(input logic [3:0] code);
    case (code)
      TC_U8, TC_I8:             return 2;
      TC_U16, TC_I16:           return 3;
      TC_U32, TC_I32, TC_FLOAT: return 5;
      TC_ARR3:                  return 4;
      TC_ARR5:                  return 6;
      TC_ARR6:                  return 7;
      TC_ARR7, TC_DOUBLE:       return 8;
      default:                  return 1;
    endcase
  endfunction

  // bytes of the value that take part in the compare
  function automatic int value_width(input logic [3:0] code);
    case (code)
      TC_U8, TC_I8:             return 1;
      TC_U16, TC_I16:           return 2;
      TC_U32, TC_I32, TC_FLOAT: return 4;
      TC_ARR3:                  return 3;
      TC_ARR5:                  return 5;
      TC_ARR6:                  return 6;
      TC_ARR7:                  return 7;
      TC_DOUBLE:                return 8;
      default:                  return 0;
    endcase
  endfunction

  function automatic logic [63:0] low_bytes_mask(input int nbytes);
    if (nbytes >= 8) return '1;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  // work out the result of one accepted request and update the shadow state
  task automatic predict_frame_result(input cov_request_t rq);
    frame_result_t res;
    queued_frame_t fr;
    logic [63:0]   m;
    logic [63:0]   old;
    int            len;
    res = '0;
    if (rq.req_type == REQ_SAMPLE) begin
      n_samples++;
      // unknown type codes are ignored
      if (rq.type_code < NUM_TYPES) begin
        m = low_bytes_mask(value_width(rq.type_code));
        old = last_value[rq.entry];
        if (((old ^ rq.sample_value) & m) != '0) begin
          res.changed = 1'b1;
          last_value[rq.entry] = (old & ~m) | (rq.sample_value & m);
          fr.segment = rq.segment;
          fr.slot = rq.slot;
          fr.type_code = rq.type_code;
          fr.value = rq.sample_value & m;
          // a full queue drops the frame but the last value still moves
          if (rq.hi_prio) begin
            if (high_frames.size() >= QUEUE_SLOTS) res.dropped = 1'b1;
            else high_frames.push_back(fr);
          end else begin
            if (low_frames.size() >= QUEUE_SLOTS) res.dropped = 1'b1;
            else low_frames.push_back(fr);
          end
          if (res.dropped) n_dropped++;
          else n_queued++;
        end
      end
    end else begin
      n_transmits++;
      if (high_frames.size() != 0 || low_frames.size() != 0) begin
        if (high_frames.size() != 0) fr = high_frames.pop_front();
        else fr = low_frames.pop_front();
        len = wire_length(fr.type_code);
        res.frame_valid = 1'b1;
        res.frame_id = {node_id, 6'b0} + {5'b0, fr.segment};
        res.frame_bytes = 4'(len);
        // slot byte first, then len-1 value bytes
        res.frame_payload = {56'b0, fr.slot} | ((fr.value & low_bytes_mask(len - 1)) << 8);
        n_sent++;
      end else begin
        n_empty_tx++;
      end
    end
    expected_results.push_back(res);
  endtask

  // request driver: holds start until the block takes the request
  always @(posedge clk_i) begin : request_driver
    logic taken;
    taken = start && !busy;
    if (taken) predict_frame_result(request_on_port);
    if (!start || taken) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        request_on_port = pending_requests.pop_front();
        holding = 1'b1;
        start           <= 1'b1;
        req_type_i      <= request_on_port.req_type;
        entry_i         <= request_on_port.entry;
        segment_i       <= request_on_port.segment;
        slot_i          <= request_on_port.slot;
        type_code_i     <= request_on_port.type_code;
        hi_prio_i       <= request_on_port.hi_prio;
        sample_value_i  <= request_on_port.sample_value;
      end else begin
        holding = 1'b0;
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result monitor: every done_o pulse is compared with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    frame_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, {changed_o, dropped_o, frame_valid_o, frame_id_o, frame_bytes_o,
                         frame_payload_o});
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("changed", 64'(want.changed), 64'(changed_o));
        check_field("dropped", 64'(want.dropped), 64'(dropped_o));
        check_field("frame_valid", 64'(want.frame_valid), 64'(frame_valid_o));
        check_field("frame_id", 64'(want.frame_id), 64'(frame_id_o));
        check_field("frame_bytes", 64'(want.frame_bytes), 64'(frame_bytes_o));
        check_field("frame_payload", want.frame_payload, frame_payload_o);
      end
    end
  end

  function automatic cov_request_t make_request(input logic rt, input logic [7:0] ent,
                                                input logic [5:0] seg, input logic [7:0] slt,
                                                input logic [3:0] code, input logic hi,
                                                input logic [63:0] val);
    cov_request_t rq;
    rq.req_type = rt;
    rq.entry = ent;
    rq.segment = seg;
    rq.slot = slt;
    rq.type_code = code;
    rq.hi_prio = hi;
    rq.sample_value = val;
    return rq;
  endfunction

  // random request; sample values often repeat or slightly alter the last one sent
  task automatic add_random_request(input int tx_pct, input int hi_pct);
    cov_request_t rq;
    int           pick;
    rq.req_type = ($urandom_range(0, 99) < tx_pct) ? REQ_TX : REQ_SAMPLE;
    if ($urandom_range(0, 99) < 70)
      rq.entry = 8'($urandom_range(0, 3)) | (($urandom_range(0, 1) != 0) ? 8'hFC : 8'h00);
    else
      rq.entry = 8'($urandom);
    rq.segment = 6'($urandom);
    rq.slot = 8'($urandom);
    if ($urandom_range(0, 99) < 95) rq.type_code = 4'($urandom_range(0, 11));
    else rq.type_code = 4'($urandom_range(12, 15));
    rq.hi_prio = ($urandom_range(0, 99) < hi_pct);
    pick = $urandom_range(0, 99);
    if (pick < 25) rq.sample_value = recent_value[rq.entry];
    else if (pick < 35) rq.sample_value = recent_value[rq.entry] ^ {32'($urandom), 32'h0};
    else if (pick < 45)
      rq.sample_value = recent_value[rq.entry] ^ (64'd1 << $urandom_range(0, 63));
    else rq.sample_value = {32'($urandom), 32'($urandom)};
    if (rq.req_type == REQ_SAMPLE) recent_value[rq.entry] = rq.sample_value;
    pending_requests.push_back(rq);
  endtask

  task automatic write_node_id(input logic [4:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    node_id = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || holding || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin : stimulus
    int         phase;
    int         n;
    int         mode;
    int         tx_pct;
    int         hi_pct;
    logic [4:0] node_setting [4];
    int         phase_gap [4];
    for (int i = 0; i < DICT_SIZE; i++) begin
      last_value[i] = '0;
      recent_value[i] = '0;
    end
    node_setting[0] = 5'd31;
    node_setting[1] = 5'd0;
    node_setting[2] = 5'($urandom_range(2, 30));
    node_setting[3] = 5'd1;
    // no idling, sender idle 82%, receiver stall (cannot apply), both at 37%
    phase_gap[0] = 0;
    phase_gap[1] = 82;
    phase_gap[2] = 0;
    phase_gap[3] = 37;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block clears its last-value store before it takes requests
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);

    // directed: transmit on empty queues
    pending_requests.push_back(make_request(REQ_TX, 8'h00, 6'h00, 8'h00, TC_U8, 1'b0, '0));
    // every type code once, field extremes alternating
    for (int c = TC_U8; c <= TC_DOUBLE; c++)
      pending_requests.push_back(make_request(REQ_SAMPLE, 8'(c), (c % 2) ? 6'h3F : 6'h00,
                                              (c % 2) ? 8'hFF : 8'h00, 4'(c), 1'(c % 2),
                                              64'hFFFF_FFFF_FFFF_FFFF));
    // unknown type codes are ignored
    for (int c = 12; c < 16; c++)
      pending_requests.push_back(make_request(REQ_SAMPLE, 8'hFF, 6'h3F, 8'hFF, 4'(c), 1'b1,
                                              64'hFFFF_FFFF_FFFF_FFFF));
    // unchanged value against reset contents
    pending_requests.push_back(make_request(REQ_SAMPLE, 8'hFF, 6'h3F, 8'hFF, TC_DOUBLE, 1'b1,
                                            64'h0));
    // upper bytes outside the type width are ignored
    pending_requests.push_back(make_request(REQ_SAMPLE, 8'h00, 6'h15, 8'h5A, TC_U8, 1'b0,
                                            64'h1234_5678_9ABC_DEFF));
    // wider type over the same entry sees the upper bytes change
    pending_requests.push_back(make_request(REQ_SAMPLE, 8'h00, 6'h2A, 8'hA5, TC_DOUBLE, 1'b1,
                                            64'hFFFF_FFFF_FFFF_FFFF));
    // transmits, served from the high queue first
    repeat (6)
      pending_requests.push_back(make_request(REQ_TX, 8'hFF, 6'h3F, 8'hFF, 4'hF, 1'b1, '1));
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      write_node_id(node_setting[phase]);
      gap_pct = phase_gap[phase];
      n = 0;
      while (n < 188) begin
        // bursts that fill one queue past full, drain both, or mix
        mode = $urandom_range(0, 2);
        if (mode == 0) begin
          tx_pct = 3;
          hi_pct = ($urandom_range(0, 1) != 0) ? 90 : 10;
        end else if (mode == 1) begin
          tx_pct = 80;
          hi_pct = 50;
        end else begin
          tx_pct = 45;
          hi_pct = 50;
        end
        for (int k = 0; k < 30 && n < 188; k++) begin
          add_random_request(tx_pct, hi_pct);
          n++;
        end
      end
      wait_drained();
    end

    repeat (6) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("Ran %0d sample and %0d transmit requests over four pacing phases, node_id %0d..%0d.",
             n_samples, n_transmits, 0, 31);
    $display("Frames queued %0d, dropped on full queue %0d, sent %0d, empty transmits %0d.",
             n_queued, n_dropped, n_sent, n_empty_tx);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
